@@ rtl/psa_pkg.sv @@
// Shared types, constants and the arctangent table of the pixel-to-servo-angle block.
// Used by every file in rtl/; has no dependencies of its own.
package psa_pkg;

  localparam int COORD_BITS      = 12;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TABLE_LEN       = 24;
  localparam int GUARD_SHIFT     = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int VD_W       = 16;
  localparam int VOFS_W     = 16;

  // x/y datapath: distance << 16 grown by the CORDIC gain stays below 2^34
  localparam int XW = 36;
  // angle accumulator in degrees with 32 fraction bits, sum of table below 100 deg
  localparam int ZW = 41;

  localparam int DEG_W = ANGLE_FRAC_BITS + 8;
  localparam int RW    = ANGLE_FRAC_BITS + 11;
  localparam int OUT_W = ANGLE_FRAC_BITS + 9;

  localparam int ANGLE_RIGHT = 90 << ANGLE_FRAC_BITS;
  localparam int ANGLE_FULL  = 180 << ANGLE_FRAC_BITS;

  localparam logic signed [ZW-1:0] Z_RIGHT = ZW'(64'd90 << 32);
  localparam logic [ZW-1:0]        Z_HALF  = ZW'(64'd1 << (31 - ANGLE_FRAC_BITS));

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SCREEN_WIDTH      = 3'd0,
    CFG_SCREEN_WIDTH_MID  = 3'd1,
    CFG_SCREEN_HEIGHT     = 3'd2,
    CFG_SCREEN_HEIGHT_MID = 3'd3,
    CFG_VIEW_DISTANCE     = 3'd4,
    CFG_VERTICAL_OFFSET   = 3'd5
  } cfg_addr_e;

  // Flags that ride along with each item through the cell chain
  typedef struct packed {
    logic vertical;
    logic below;
    logic zero;
  } side_t;

  // atan(2^-i) in degrees, scaled by 2^32 and rounded
  function automatic logic [ZW-1:0] atan_deg_q32(input int unsigned idx);
    logic [ZW-1:0] v;
    case (idx)
      0:  v = 41'd193273528320;
      1:  v = 41'd114096026022;
      2:  v = 41'd60285206654;
      3:  v = 41'd30601712202;
      4:  v = 41'd15360239169;
      5:  v = 41'd7687607524;
      6:  v = 41'd3844741810;
      7:  v = 41'd1922488224;
      8:  v = 41'd961258780;
      9:  v = 41'd480631223;
      10: v = 41'd240315841;
      11: v = 41'd120157949;
      12: v = 41'd60078978;
      13: v = 41'd30039490;
      14: v = 41'd15019745;
      15: v = 41'd7509872;
      16: v = 41'd3754936;
      17: v = 41'd1877468;
      18: v = 41'd938734;
      19: v = 41'd469367;
      20: v = 41'd234684;
      21: v = 41'd117342;
      22: v = 41'd58671;
      23: v = 41'd29335;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/psa_if.sv @@
// Valid/ready stream interfaces for the coordinate input and the angle output.
// Depends on psa_pkg for field widths.
interface psa_in_if import psa_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [COORD_BITS-1:0] coord;

  modport source (output valid, output opcode, output coord, input ready);
  modport sink   (input valid, input opcode, input coord, output ready);
endinterface

interface psa_out_if import psa_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] angle_q8;

  modport source (output valid, output angle_q8, input ready);
  modport sink   (input valid, input angle_q8, output ready);
endinterface

@@ rtl/psa_front.sv @@
// Front stage: clamp the coordinate, take its offset from the centre, seed the CORDIC vector.
// Depends on psa_pkg.
module psa_front import psa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic                  opcode_i,
  input  logic [COORD_BITS-1:0] coord_i,
  input  logic [COORD_BITS-1:0] width_i,
  input  logic [COORD_BITS-1:0] width_mid_i,
  input  logic [COORD_BITS-1:0] height_i,
  input  logic [COORD_BITS-1:0] height_mid_i,
  input  logic [VD_W-1:0]       view_dist_i,
  output logic                  valid_o,
  output logic signed [XW-1:0]  x_o,
  output logic signed [XW-1:0]  y_o,
  output side_t                 side_o
);

  logic                  valid_q;
  logic signed [XW-1:0]  x_q, x_d;
  logic signed [XW-1:0]  y_q, y_d;
  side_t                 side_q, side_d;
  logic [COORD_BITS-1:0] lim, mid, c, off;

  always_comb begin
    lim = opcode_i ? height_i : width_i;
    mid = opcode_i ? height_mid_i : width_mid_i;
    c   = (coord_i > lim) ? lim : coord_i;
    side_d.vertical = opcode_i;
    side_d.below    = c < mid;
    off = side_d.below ? (mid - c) : (c - mid);
    side_d.zero     = off == '0;
    x_d = $signed(XW'(view_dist_i) << GUARD_SHIFT);
    y_d = $signed(XW'(off) << GUARD_SHIFT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign side_o  = side_q;

endmodule

@@ rtl/psa_cordic_cell.sv @@
// One CORDIC vectoring cell: rotate toward y = 0 by atan(2^-STAGE) and register.
// Depends on psa_pkg for widths and the angle table.
module psa_cordic_cell import psa_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  side_t                side_i,
  output logic                 valid_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output side_t                side_o
);

  localparam logic signed [ZW-1:0] ANG = $signed(atan_deg_q32(STAGE));

  logic                 valid_q;
  logic signed [XW-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic signed [ZW-1:0] z_q, z_d;
  side_t                side_q;

  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (y_i[XW-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ANG;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ANG;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

@@ rtl/psa_post.sv @@
// Back end: clamp and round the CORDIC angle, then form the servo angle and saturate.
// Two register stages; the second is the output register. Depends on psa_pkg.
module psa_post import psa_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [ZW-1:0]     z_i,
  input  side_t                    side_i,
  input  logic signed [VOFS_W-1:0] vert_ofs_i,
  output logic                     valid_o,
  output logic signed [OUT_W-1:0]  angle_o
);

  localparam logic signed [RW-1:0] R_RIGHT = RW'(ANGLE_RIGHT);
  localparam logic signed [RW-1:0] R_FULL  = RW'(ANGLE_FULL);

  logic                    deg_valid_q, out_valid_q;
  logic [DEG_W-1:0]        deg_q, deg_d;
  side_t                   side_q;
  logic [ZW-1:0]           zc, zr;
  logic signed [RW-1:0]    r, r_sat, deg_s, ofs_s;
  logic                    add_deg;
  logic signed [OUT_W-1:0] angle_q;

  // Stage one: clamp to [0, 90] degrees, round half up
  always_comb begin
    if (z_i < 0) begin
      zc = '0;
    end else if (z_i > Z_RIGHT) begin
      zc = Z_RIGHT;
    end else begin
      zc = z_i;
    end
    zr = zc + Z_HALF;
    deg_d = side_i.zero ? '0 : zr[32-ANGLE_FRAC_BITS +: DEG_W];
  end

  // Stage two: fold the angle around 90 degrees, apply the vertical trim, saturate
  always_comb begin
    deg_s   = $signed(RW'(deg_q));
    ofs_s   = RW'(vert_ofs_i);
    add_deg = side_q.vertical ? !side_q.below : side_q.below;
    r       = add_deg ? (R_RIGHT + deg_s) : (R_RIGHT - deg_s);
    if (side_q.vertical) begin
      r = r - ofs_s;
    end
    if (r > R_FULL) begin
      r_sat = R_FULL;
    end else if (r < -R_FULL) begin
      r_sat = -R_FULL;
    end else begin
      r_sat = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      deg_valid_q <= valid_i;
      out_valid_q <= deg_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      deg_q   <= deg_d;
      side_q  <= side_i;
      angle_q <= r_sat[OUT_W-1:0];
    end
  end

  assign valid_o = out_valid_q;
  assign angle_o = angle_q;

endmodule

@@ rtl/pixel_to_servo_angle_unit.sv @@
// Top level: config registers, front stage, chain of CORDIC cells, angle back end.
// Depends on psa_pkg, psa_if, psa_front, psa_cordic_cell and psa_post.
//
//   channel   dir  handshake       payload
//   in_ch     in   valid / ready   opcode (0 = x, 1 = y), coord [11:0]
//   out_ch    out  valid / ready   angle_q8 [16:0] signed, Q8.8 degrees
//   cfg       in   cfg_we_i        cfg_addr_i [2:0], cfg_wdata_i [15:0]
//
// One item enters per clock while the output is not stalled; each item passes the front
// stage, one cell per CORDIC iteration, the round stage and the output register.
// Reset loads the screen defaults (640x480, centre 320/240, distance 500, no
// vertical trim) and empties the chain.
// The chain moves as one: while the output register holds an item that is not
// taken, every stage holds and in_ch.ready is low.
module pixel_to_servo_angle_unit import psa_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  psa_in_if.sink                in_ch,
  psa_out_if.source             out_ch,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // Configuration registers
  logic [COORD_BITS-1:0]    width_q, width_mid_q, height_q, height_mid_q;
  logic [VD_W-1:0]          view_dist_q;
  logic signed [VOFS_W-1:0] vert_ofs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= COORD_BITS'(640);
      width_mid_q  <= COORD_BITS'(320);
      height_q     <= COORD_BITS'(480);
      height_mid_q <= COORD_BITS'(240);
      view_dist_q  <= VD_W'(500);
      vert_ofs_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_e'(cfg_addr_i))
        CFG_SCREEN_WIDTH:      width_q      <= cfg_wdata_i[COORD_BITS-1:0];
        CFG_SCREEN_WIDTH_MID:  width_mid_q  <= cfg_wdata_i[COORD_BITS-1:0];
        CFG_SCREEN_HEIGHT:     height_q     <= cfg_wdata_i[COORD_BITS-1:0];
        CFG_SCREEN_HEIGHT_MID: height_mid_q <= cfg_wdata_i[COORD_BITS-1:0];
        CFG_VIEW_DISTANCE:     view_dist_q  <= cfg_wdata_i[VD_W-1:0];
        CFG_VERTICAL_OFFSET:   vert_ofs_q   <= $signed(cfg_wdata_i[VOFS_W-1:0]);
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Advance the whole chain unless the output register is stuck
  logic adv;
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // Cell chain taps: index 0 is the front stage, index k the output of cell k-1
  logic                 cv [0:CORDIC_STAGES];
  logic signed [XW-1:0] cx [0:CORDIC_STAGES];
  logic signed [XW-1:0] cy [0:CORDIC_STAGES];
  logic signed [ZW-1:0] cz [0:CORDIC_STAGES];
  side_t                cs [0:CORDIC_STAGES];

  psa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (adv),
    .valid_i      (in_ch.valid),
    .opcode_i     (in_ch.opcode),
    .coord_i      (in_ch.coord),
    .width_i      (width_q),
    .width_mid_i  (width_mid_q),
    .height_i     (height_q),
    .height_mid_i (height_mid_q),
    .view_dist_i  (view_dist_q),
    .valid_o      (cv[0]),
    .x_o          (cx[0]),
    .y_o          (cy[0]),
    .side_o       (cs[0])
  );

  // Angle accumulation starts at zero
  assign cz[0] = '0;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    psa_cordic_cell #(
      .STAGE (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (cv[k]),
      .x_i     (cx[k]),
      .y_i     (cy[k]),
      .z_i     (cz[k]),
      .side_i  (cs[k]),
      .valid_o (cv[k+1]),
      .x_o     (cx[k+1]),
      .y_o     (cy[k+1]),
      .z_o     (cz[k+1]),
      .side_o  (cs[k+1])
    );
  end

  // The final x and y are not needed; only the accumulated angle goes on
  psa_post u_post (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (cv[CORDIC_STAGES]),
    .z_i        (cz[CORDIC_STAGES]),
    .side_i     (cs[CORDIC_STAGES]),
    .vert_ofs_i (vert_ofs_q),
    .valid_o    (out_ch.valid),
    .angle_o    (out_ch.angle_q8)
  );

`ifndef SYNTHESIS
  localparam logic signed [OUT_W-1:0] A_MAX = OUT_W'(ANGLE_FULL);

  // An accepted item shows up in the front stage on the next edge
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> cv[0])
    else $error("accepted item missing from front stage");

  // A stall freezes the last cell's occupancy and angle
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(cv[CORDIC_STAGES]) && $stable(cz[CORDIC_STAGES])))
    else $error("cell chain moved during a stall");

  // Results never leave the saturation range
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> ((out_ch.angle_q8 <= A_MAX) && (out_ch.angle_q8 >= -A_MAX)))
    else $error("angle outside +-180 degrees");
`endif

endmodule
